// ----- rtl/murmur3_32_stream_hash_unit_assert.svh -----
// assertion macros for the hash unit rtl, included by the queue
`ifndef MURMUR3_32_STREAM_HASH_UNIT_ASSERT_SVH
`define MURMUR3_32_STREAM_HASH_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define MM3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// signal must never be high outside reset
`define MM3_NEVER(label, clk, rst_n, sig, msg) \
    `MM3_ASSERT(label, clk, rst_n, !(sig), msg)

`endif

// ----- rtl/mm3_pkg.sv -----
// types, constants and helper functions of the murmur3 hash unit
package mm3_pkg;

    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;

    localparam int unsigned ROT_K = 15;
    localparam int unsigned ROT_H = 13;

    localparam logic [2:0] FULL_BYTES = 3'd4;

    // default depth of the queue between front and back, at least 2
    localparam int unsigned QUEUE_DEPTH = 4;

    // how the back part folds a word into the running hash
    typedef enum logic [1:0] {
        KIND_NONE  = 2'b00,
        KIND_TAIL  = 2'b01,
        KIND_BLOCK = 2'b10
    } t_kind;

    typedef struct packed {
        logic [31:0] k;
        logic [31:0] seed;
        logic [2:0]  count;
        logic        last;
        t_kind       kind;
    } t_item;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

// ----- rtl/mm3_front.sv -----
// front part: classifies items, masks the tail and runs the two-stage scramble on every item
module mm3_front
    import mm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_item,
    input  logic [31:0] i_seed_value,
    output logic        o_wr,
    output t_item       o_wr_item,
    input  logic        i_q_full
);

    logic        r_a_vld, n_a_vld;
    logic        r_b_vld, n_b_vld;
    t_item       r_a, n_a;
    t_item       r_b, n_b;
    logic        a_ready, b_ready, a_load, b_load;
    logic [2:0]  cnt_sat;
    logic [31:0] mask;

    assign b_ready = !r_b_vld || !i_q_full;
    assign a_ready = !r_a_vld || b_ready;
    assign a_load  = i_push && a_ready;
    assign b_load  = r_a_vld && b_ready;

    assign o_full    = !a_ready;
    assign o_wr      = r_b_vld && !i_q_full;
    assign o_wr_item = r_b;

    always_comb begin
        cnt_sat = (i_byte_count > FULL_BYTES) ? FULL_BYTES : i_byte_count;
        // the byte count only matters on the last item
        if (!i_last_item) begin
            mask = 32'hffff_ffff;
        end else begin
            case (cnt_sat)
                3'd1:    mask = 32'h0000_00ff;
                3'd2:    mask = 32'h0000_ffff;
                3'd3:    mask = 32'h00ff_ffff;
                default: mask = 32'hffff_ffff;
            endcase
        end

        n_a.seed = i_seed_value;
        n_a.last = i_last_item;
        if (!i_last_item || cnt_sat == FULL_BYTES) begin
            n_a.kind  = KIND_BLOCK;
            n_a.count = FULL_BYTES;
        end else if (cnt_sat == 3'd0) begin
            n_a.kind  = KIND_NONE;
            n_a.count = 3'd0;
        end else begin
            n_a.kind  = KIND_TAIL;
            n_a.count = cnt_sat;
        end
        n_a.k = (i_data_word & mask) * C1;

        n_b   = r_a;
        n_b.k = rotl(r_a.k, ROT_K) * C2;

        n_a_vld = a_load ? 1'b1 : (b_load ? 1'b0 : r_a_vld);
        n_b_vld = b_load ? 1'b1 : (o_wr ? 1'b0 : r_b_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a <= n_a;
        end
        if (b_load) begin
            r_b <= n_b;
        end
    end

endmodule

// ----- rtl/mm3_queue.sv -----
// short queue of scrambled items between front and back
module mm3_queue
    import mm3_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_wr_item,
    output logic  o_full,
    input  logic  i_rd,
    output t_item o_rd_item,
    output logic  o_empty
);

    `include "murmur3_32_stream_hash_unit_assert.svh"

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full    = (r_cnt == CNT_FULL);
    assign o_empty   = (r_cnt == '0);
    assign o_rd_item = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_wr) begin
            n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
        end
        if (i_rd) begin
            n_rp = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wr_item;
        end
    end

    `MM3_NEVER(a_q_overflow, i_clk, i_rst_n, i_wr && o_full, "queue written while full")
    `MM3_NEVER(a_q_underflow, i_clk, i_rst_n, i_rd && o_empty, "queue read while empty")
    `MM3_ASSERT(a_q_count, i_clk, i_rst_n, (i_wr && !i_rd) |=> (r_cnt == $past(r_cnt) + 1'b1), "queue count lost a write")
    `MM3_ASSERT(a_q_ptrs, i_clk, i_rst_n, o_empty |-> (r_wp == r_rp), "queue pointers disagree when empty")

endmodule

// ----- rtl/mm3_back.sv -----
// back part: running hash accumulator, length count and pipelined fmix32 finalizer
module mm3_back
    import mm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_rd,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_hash_value
);

    logic        r_start, n_start;
    logic [31:0] r_hash, n_hash;
    logic [31:0] r_len, n_len;

    logic        r_f0_vld, r_f1_vld, r_f2_vld, r_out_vld;
    logic [31:0] r_f0, r_f1, r_f2, r_out;
    logic [31:0] n_f0, n_f1, n_f2, n_out;
    logic        out_ready, f2_ready, f1_ready, f0_ready;
    logic        f0_load, f1_load, f2_load, out_load;
    logic [31:0] h0, hx, len0, x1, x2;

    assign out_ready = !r_out_vld || i_pop;
    assign f2_ready  = !r_f2_vld || out_ready;
    assign f1_ready  = !r_f1_vld || f2_ready;
    assign f0_ready  = !r_f0_vld || f1_ready;

    assign o_rd     = !i_q_empty && (!i_q_item.last || f0_ready);
    assign f0_load  = o_rd && i_q_item.last;
    assign f1_load  = r_f0_vld && f1_ready;
    assign f2_load  = r_f1_vld && f2_ready;
    assign out_load = r_f2_vld && out_ready;

    assign o_empty      = !r_out_vld;
    assign o_hash_value = r_out;

    always_comb begin
        h0   = r_start ? i_q_item.seed : r_hash;
        len0 = r_start ? 32'd0 : r_len;
        hx   = h0 ^ i_q_item.k;
        case (i_q_item.kind)
            KIND_BLOCK: n_hash = (rotl(hx, ROT_H) * 32'd5) + C3;
            KIND_TAIL:  n_hash = hx;
            default:    n_hash = h0;
        endcase
        n_len = len0 + {29'd0, i_q_item.count};

        n_f0 = n_hash ^ n_len;
        x1   = r_f0 ^ (r_f0 >> 16);
        n_f1 = x1 * F1;
        x2   = r_f1 ^ (r_f1 >> 13);
        n_f2 = x2 * F2;
        n_out = r_f2 ^ (r_f2 >> 16);

        n_start = r_start;
        if (o_rd) begin
            n_start = i_q_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= 1'b1;
            r_hash    <= '0;
            r_len     <= '0;
            r_f0_vld  <= 1'b0;
            r_f1_vld  <= 1'b0;
            r_f2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_start <= n_start;
            if (o_rd) begin
                // a finished message leaves the accumulator cleared
                r_hash <= i_q_item.last ? 32'd0 : n_hash;
                r_len  <= i_q_item.last ? 32'd0 : n_len;
            end
            r_f0_vld  <= f0_load  ? 1'b1 : (f1_load  ? 1'b0 : r_f0_vld);
            r_f1_vld  <= f1_load  ? 1'b1 : (f2_load  ? 1'b0 : r_f1_vld);
            r_f2_vld  <= f2_load  ? 1'b1 : (out_load ? 1'b0 : r_f2_vld);
            r_out_vld <= out_load ? 1'b1 : (i_pop    ? 1'b0 : r_out_vld);
        end
    end

    always_ff @(posedge i_clk) begin
        if (f0_load) begin
            r_f0 <= n_f0;
        end
        if (f1_load) begin
            r_f1 <= n_f1;
        end
        if (f2_load) begin
            r_f2 <= n_f2;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/murmur3_32_stream_hash_unit.sv -----
// top level of the streaming murmur3 x86_32 hash unit
//
//  channel  | handshake       | payload
//  ---------+-----------------+-----------------------------------------------
//  input    | push / full     | i_data_word, i_byte_count, i_last_item, i_seed_value
//  result   | empty / pop     | o_hash_value
//
// one item is taken per cycle when nothing stalls; an item passes the front registers
// r_a and r_b before it is written to the queue, and a hash passes the finalizer
// registers r_f0, r_f1, r_f2 and r_out after its last item leaves the queue
// the back part's accumulator loop handles one word per cycle when nothing stalls
// reset is synchronous and leaves the next item starting a new message
// a stalled result fills the finalizer, then the queue, then the front stages
module murmur3_32_stream_hash_unit
    import mm3_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_item,
    input  logic [31:0] i_seed_value,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_hash_value
);

    logic  q_wr, q_full, q_rd, q_empty;
    t_item q_wr_item, q_rd_item;

    mm3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last_item  (i_last_item),
        .i_seed_value (i_seed_value),
        .o_wr         (q_wr),
        .o_wr_item    (q_wr_item),
        .i_q_full     (q_full)
    );

    mm3_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_item (q_wr_item),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_rd_item (q_rd_item),
        .o_empty   (q_empty)
    );

    mm3_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_item     (q_rd_item),
        .o_rd         (q_rd),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_hash_value (o_hash_value)
    );

endmodule
